### sv/lpi_pkg.sv
package lpi_pkg;

	// Queue geometry
	localparam int QUEUE_DEPTH = 64;
	localparam int QADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	// Field and counter widths
	localparam int BYTES_W = 16;
	localparam int LEN_W = 32;
	localparam int CNT32_W = 32;
	localparam int CNT48_W = 48;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// Link modes
	localparam logic [1:0] MODE_READY = 2'd0;
	localparam logic [1:0] MODE_BUSY = 2'd1;
	localparam logic [1:0] MODE_SLEEP = 2'd2;

	// Request commands
	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_SEND = 2'd1;
	localparam logic [1:0] CMD_STAT = 2'd2;
	localparam logic [1:0] CMD_NOP = 2'd3;

	// Statistic selects
	localparam logic [2:0] STAT_IDLE = 3'd0;
	localparam logic [2:0] STAT_SLEEP = 3'd1;
	localparam logic [2:0] STAT_BUSY = 3'd2;
	localparam logic [2:0] STAT_SLEEPS = 3'd3;
	localparam logic [2:0] STAT_MAXQ = 3'd4;
	localparam logic [2:0] STAT_INTEGRAL = 3'd5;
	localparam logic [2:0] STAT_SENT = 3'd6;
	localparam logic [2:0] STAT_DROPPED = 3'd7;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE_TIME = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_READY_WAKE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_WAKE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_RUNWAY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 3'd4;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] frame_bytes;
		logic [15:0] fabric_delay;
		logic [2:0]  stat_select;
	} req_t;

	typedef struct packed {
		logic [1:0]  link_state;
		logic        tx_started;
		logic [31:0] tx_length;
		logic        tx_done;
		logic        frame_dropped;
		logic        entered_sleep;
		logic [6:0]  queue_count;
		logic [47:0] stat_value;
	} rsp_t;

	typedef struct packed {
		logic [15:0] byte_time;
		logic [15:0] ready_wake_delay;
		logic [15:0] sleep_wake_delay;
		logic [31:0] idle_runway;
		logic [6:0]  queue_limit;
	} cfg_t;

	// Saturating add for the 48-bit time counters
	function automatic logic [CNT48_W-1:0] sat_add48(logic [CNT48_W-1:0] a,
			logic [CNT48_W-1:0] b);
		logic [CNT48_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT48_W] ? {CNT48_W{1'b1}} : s[CNT48_W-1:0];
	endfunction

	// Saturating increment for the 32-bit event counters
	function automatic logic [CNT32_W-1:0] sat_inc32(logic [CNT32_W-1:0] a);
		return (&a) ? a : a + 1'b1;
	endfunction

endpackage

### sv/lpi_ram.sv
module lpi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/lpi_cfg.sv
module lpi_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr,
	input  logic [lpi_pkg::CFG_IDX_W-1:0]    index,
	input  logic [lpi_pkg::CFG_DATA_W-1:0]   data,
	output lpi_pkg::cfg_t                    cfg
);

	lpi_pkg::cfg_t cfg_q;

	// Decode register writes; ignore indexes past the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.byte_time <= 16'd8;
			cfg_q.ready_wake_delay <= 16'd0;
			cfg_q.sleep_wake_delay <= 16'd100;
			cfg_q.idle_runway <= 32'd1000;
			cfg_q.queue_limit <= 7'd64;
		end else if (wr) begin
			unique case (index)
				lpi_pkg::CFG_BYTE_TIME:   cfg_q.byte_time <= data[15:0];
				lpi_pkg::CFG_READY_WAKE:  cfg_q.ready_wake_delay <= data[15:0];
				lpi_pkg::CFG_SLEEP_WAKE:  cfg_q.sleep_wake_delay <= data[15:0];
				lpi_pkg::CFG_IDLE_RUNWAY: cfg_q.idle_runway <= data[31:0];
				lpi_pkg::CFG_QUEUE_LIMIT: cfg_q.queue_limit <= data[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/lpi_core.sv
module lpi_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  lpi_pkg::req_t req,
	input  lpi_pkg::cfg_t cfg,
	output lpi_pkg::rsp_t rsp
);

	localparam int AW = lpi_pkg::QADDR_W;
	localparam int FW = lpi_pkg::FILL_W;
	localparam int C48 = lpi_pkg::CNT48_W;
	localparam int C32 = lpi_pkg::CNT32_W;

	logic [1:0]      mode_q, n_mode;
	logic [31:0]     busy_rem_q, n_busy_rem;
	logic [31:0]     idle_el_q, n_idle_el;
	logic [AW-1:0]   head_q, n_head, tail_q, n_tail;
	logic [FW-1:0]   fill_q, n_fill, maxq_q, n_maxq;
	logic [C48-1:0]  idle_tot_q, n_idle_tot, sleep_tot_q, n_sleep_tot;
	logic [C48-1:0]  busy_tot_q, n_busy_tot, integ_q, n_integ;
	logic [C32-1:0]  sleeps_q, n_sleeps, sent_q, n_sent, drop_q, n_drop;
	logic            fwd_q;
	logic [15:0]     fwd_data_q;

	logic [15:0]     ram_rdata, head_bytes;
	logic            enq, deq, start, r_done, r_drop, r_slept, q_full;
	logic [15:0]     st_bytes, st_pen, st_fab;
	logic [31:0]     prod, len, el_inc;
	logic [33:0]     len_sum;
	logic [47:0]     stat;

	// Frame byte counts waiting while the link is busy
	lpi_ram #(
		.WIDTH (16),
		.DEPTH (lpi_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (enq),
		.waddr (tail_q),
		.wdata (req.frame_bytes),
		.raddr (n_head),
		.rdata (ram_rdata)
	);

	// Take the head entry, forwarding a write that raced its read
	assign head_bytes = fwd_q ? fwd_data_q : ram_rdata;

	// Frame length: bytes times byte time plus penalty and fabric delay
	assign prod = 32'(st_bytes) * 32'(cfg.byte_time);
	assign len_sum = 34'(prod) + 34'(st_pen) + 34'(st_fab);
	assign len = (|len_sum[33:32]) ? 32'hFFFF_FFFF : len_sum[31:0];

	assign q_full = (32'(fill_q) >= 32'(cfg.queue_limit)) ||
		(32'(fill_q) >= 32'(lpi_pkg::QUEUE_DEPTH));
	assign el_inc = lpi_pkg::sat_inc32(idle_el_q);

	// Next state for the accepted request
	always_comb begin
		n_mode = mode_q;
		n_busy_rem = busy_rem_q;
		n_idle_el = idle_el_q;
		n_idle_tot = idle_tot_q;
		n_sleep_tot = sleep_tot_q;
		n_busy_tot = busy_tot_q;
		n_integ = integ_q;
		n_sleeps = sleeps_q;
		n_sent = sent_q;
		n_drop = drop_q;
		n_maxq = maxq_q;
		enq = 1'b0;
		deq = 1'b0;
		start = 1'b0;
		r_done = 1'b0;
		r_drop = 1'b0;
		r_slept = 1'b0;
		st_bytes = req.frame_bytes;
		st_pen = cfg.ready_wake_delay;
		st_fab = req.fabric_delay;
		stat = '0;
		if (accept) begin
			case (req.cmd)
				lpi_pkg::CMD_TICK: begin
					n_integ = lpi_pkg::sat_add48(integ_q, C48'(fill_q));
					case (mode_q)
						lpi_pkg::MODE_BUSY: begin
							n_busy_tot = lpi_pkg::sat_add48(busy_tot_q, 48'd1);
							if (busy_rem_q <= 32'd1) begin
								r_done = 1'b1;
								n_mode = lpi_pkg::MODE_READY;
								n_busy_rem = '0;
								n_idle_el = '0;
								if (fill_q != '0) begin
									deq = 1'b1;
									start = 1'b1;
									st_bytes = head_bytes;
									st_fab = '0;
								end
							end else begin
								n_busy_rem = busy_rem_q - 1'b1;
							end
						end
						lpi_pkg::MODE_SLEEP: begin
							n_sleep_tot = lpi_pkg::sat_add48(sleep_tot_q, 48'd1);
						end
						default: begin
							n_idle_tot = lpi_pkg::sat_add48(idle_tot_q, 48'd1);
							if (el_inc >= cfg.idle_runway) begin
								n_mode = lpi_pkg::MODE_SLEEP;
								n_idle_el = '0;
								n_sleeps = lpi_pkg::sat_inc32(sleeps_q);
								r_slept = 1'b1;
							end else begin
								n_idle_el = el_inc;
							end
						end
					endcase
				end
				lpi_pkg::CMD_SEND: begin
					if (mode_q == lpi_pkg::MODE_BUSY) begin
						if (!q_full) begin
							enq = 1'b1;
							if (fill_q + 1'b1 > maxq_q) begin
								n_maxq = fill_q + 1'b1;
							end
						end else begin
							r_drop = 1'b1;
							n_drop = lpi_pkg::sat_inc32(drop_q);
						end
					end else begin
						start = 1'b1;
						if (mode_q == lpi_pkg::MODE_SLEEP) begin
							st_pen = cfg.sleep_wake_delay;
						end
					end
				end
				lpi_pkg::CMD_STAT: begin
					case (req.stat_select)
						lpi_pkg::STAT_IDLE:     stat = idle_tot_q;
						lpi_pkg::STAT_SLEEP:    stat = sleep_tot_q;
						lpi_pkg::STAT_BUSY:     stat = busy_tot_q;
						lpi_pkg::STAT_SLEEPS:   stat = 48'(sleeps_q);
						lpi_pkg::STAT_MAXQ:     stat = 48'(maxq_q);
						lpi_pkg::STAT_INTEGRAL: stat = integ_q;
						lpi_pkg::STAT_SENT:     stat = 48'(sent_q);
						default:                stat = 48'(drop_q);
					endcase
				end
				default: ;
			endcase
		end
		// Start a frame: busy, load length, count it
		if (start) begin
			n_mode = lpi_pkg::MODE_BUSY;
			n_busy_rem = len;
			n_idle_el = '0;
			n_sent = lpi_pkg::sat_inc32(sent_q);
		end
	end

	// Advance the queue pointers
	always_comb begin
		n_head = head_q;
		n_tail = tail_q;
		n_fill = fill_q;
		if (deq) begin
			n_head = (head_q == AW'(lpi_pkg::QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
			n_fill = fill_q - 1'b1;
		end
		if (enq) begin
			n_tail = (tail_q == AW'(lpi_pkg::QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			n_fill = fill_q + 1'b1;
		end
	end

	// Hold control state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= lpi_pkg::MODE_READY;
			busy_rem_q <= '0;
			idle_el_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
			maxq_q <= '0;
			idle_tot_q <= '0;
			sleep_tot_q <= '0;
			busy_tot_q <= '0;
			integ_q <= '0;
			sleeps_q <= '0;
			sent_q <= '0;
			drop_q <= '0;
			fwd_q <= 1'b0;
		end else begin
			mode_q <= n_mode;
			busy_rem_q <= n_busy_rem;
			idle_el_q <= n_idle_el;
			head_q <= n_head;
			tail_q <= n_tail;
			fill_q <= n_fill;
			maxq_q <= n_maxq;
			idle_tot_q <= n_idle_tot;
			sleep_tot_q <= n_sleep_tot;
			busy_tot_q <= n_busy_tot;
			integ_q <= n_integ;
			sleeps_q <= n_sleeps;
			sent_q <= n_sent;
			drop_q <= n_drop;
			fwd_q <= enq && (tail_q == n_head);
		end
	end

	// Capture write data for the forwarding path
	always_ff @(posedge clk) begin
		fwd_data_q <= req.frame_bytes;
	end

	// Assemble the result
	always_comb begin
		rsp.link_state = n_mode;
		rsp.tx_started = start;
		rsp.tx_length = start ? len : '0;
		rsp.tx_done = r_done;
		rsp.frame_dropped = r_drop;
		rsp.entered_sleep = r_slept;
		rsp.queue_count = 7'(n_fill);
		rsp.stat_value = stat;
	end

	// Frames wait only behind a busy link
	assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != '0) |-> (mode_q == lpi_pkg::MODE_BUSY))
		else $error("queued frames while link not busy");

	// Idle time runs only in ready
	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != lpi_pkg::MODE_READY) |-> (idle_el_q == '0))
		else $error("idle time kept outside ready");

	// Pointers and fill agree
	assert property (@(posedge clk) disable iff (!arst_n)
		tail_q == AW'((32'(head_q) + 32'(fill_q)) % lpi_pkg::QUEUE_DEPTH))
		else $error("queue pointers and fill disagree");

	// Fill stays within the queue
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= 32'(lpi_pkg::QUEUE_DEPTH))
		else $error("queue fill past depth");

endmodule

### sv/lpi_obuf.sv
module lpi_obuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lpi_pkg::rsp_t din,
	output logic          room,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output lpi_pkg::rsp_t rsp
);

	logic          out_valid_q, skid_valid_q, pop;
	lpi_pkg::rsp_t out_q, skid_q;

	assign pop = out_valid_q && rsp_ready;
	assign room = !skid_valid_q;
	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	// Hold valid flags for the output and skid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= skid_valid_q;
			skid_valid_q <= 1'b0;
		end
	end

	// Move payloads: new result to output or skid, skid to output on drain
	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_valid_q || pop) begin
				out_q <= din;
			end else begin
				skid_q <= din;
			end
		end else if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	// Skid holds a result only behind a held output
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result with output empty");

endmodule

### sv/link_low_power_idle_tx_controller_unit.sv
// Transmit-side low-power-idle link controller. One request (tick, frame send or
// statistics read) is taken per clock, and its result is registered in the output
// register when that is free, else in a second result register that absorbs one
// stalled result, so requests keep flowing until two results wait unread. Frames queued
// behind a busy link sit in a 64-entry single-port-read RAM whose head entry is
// read ahead every cycle, so a finishing frame hands over to the next queued one
// on the same tick; no clearing pass is needed after reset. Configuration
// writes are always taken and must be issued while the controller is idle.
module link_low_power_idle_tx_controller_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  lpi_pkg::req_t                   req,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output lpi_pkg::rsp_t                   rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lpi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lpi_pkg::CFG_DATA_W-1:0]  cfg_data
);

	lpi_pkg::cfg_t cfg;
	lpi_pkg::rsp_t core_rsp;
	logic          accept, room;

	assign cfg_ready = 1'b1;
	assign req_ready = room;
	assign accept = req_valid && room;

	lpi_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg_valid),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	lpi_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.cfg    (cfg),
		.rsp    (core_rsp)
	);

	lpi_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.din       (core_rsp),
		.room      (room),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

### dv/tb.sv
module tb;
	import lpi_pkg::*;

	// Sends that would hold the link longer than this are reshaped or turned into ticks
	localparam longint QUICK_FRAME_TICKS = 96;
	// A phase may allow a few frames up to this length
	localparam longint SLOW_FRAME_TICKS = 140000;
	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	typedef struct packed {
		req_t stim;
		bit   typed;
		rsp_t golden;
	} dir_row_t;

	typedef struct {
		cfg_t regs;
		int   items;
		int   send_pct;
		int   long_frames;
		bit   steady;
	} phase_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Link state mirror
	cfg_t cur_cfg = '{16'd8, 16'd0, 16'd100, 32'd1000, 7'd64};
	logic [1:0] lk_mode = MODE_READY;
	logic [31:0] lk_left = '0;
	logic [31:0] lk_idle_run = '0;
	logic [BYTES_W-1:0] fifo_bytes [QUEUE_DEPTH];
	logic [QADDR_W-1:0] fifo_rd = '0;
	logic [QADDR_W-1:0] fifo_wr = '0;
	logic [FILL_W-1:0] fifo_fill = '0;
	logic [FILL_W-1:0] peak_fill = '0;
	logic [47:0] tot_idle = '0;
	logic [47:0] tot_sleep = '0;
	logic [47:0] tot_busy = '0;
	logic [47:0] fill_area = '0;
	logic [31:0] n_sleeps = '0;
	logic [31:0] n_sent = '0;
	logic [31:0] n_dropped = '0;

	rsp_t expected_q [$];
	int mismatches = 0;
	int results_seen = 0;
	int cycle_count = 0;
	int long_left = 0;
	bit steady = 1'b0;

	// Directed opening: reset values, field extremes, every command, a zero-length frame
	dir_row_t script [18] = '{
		'{'{CMD_STAT, 16'h0000, 16'h0000, STAT_IDLE}, 1'b1, '0},
		'{'{CMD_NOP, 16'hFFFF, 16'hFFFF, STAT_DROPPED}, 1'b1, '0},
		'{'{CMD_STAT, 16'hFFFF, 16'h0000, STAT_DROPPED}, 1'b1, '0},
		'{'{CMD_TICK, 16'hA5A5, 16'h5A5A, STAT_SENT}, 1'b0, '0},
		'{'{CMD_STAT, 16'h0000, 16'hFFFF, STAT_IDLE}, 1'b0, '0},
		'{'{CMD_SEND, 16'h0000, 16'h0000, STAT_IDLE}, 1'b1,
			'{MODE_BUSY, 1'b1, 32'd0, 1'b0, 1'b0, 1'b0, 7'd0, 48'd0}},
		'{'{CMD_SEND, 16'h0001, 16'hFFFF, STAT_DROPPED}, 1'b1,
			'{MODE_BUSY, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0, 7'd1, 48'd0}},
		'{'{CMD_NOP, 16'h1234, 16'h0000, STAT_BUSY}, 1'b0, '0},
		'{'{CMD_SEND, 16'h0002, 16'h0000, STAT_IDLE}, 1'b0, '0},
		'{'{CMD_STAT, 16'h0000, 16'h0000, STAT_MAXQ}, 1'b0, '0},
		'{'{CMD_TICK, 16'h0000, 16'h0000, STAT_IDLE}, 1'b0, '0},
		'{'{CMD_SEND, 16'h0000, 16'h0000, STAT_IDLE}, 1'b0, '0},
		'{'{CMD_STAT, 16'h0000, 16'h0000, STAT_INTEGRAL}, 1'b0, '0},
		'{'{CMD_STAT, 16'h0000, 16'h0000, STAT_BUSY}, 1'b0, '0},
		'{'{CMD_STAT, 16'h0000, 16'h0000, STAT_SLEEP}, 1'b0, '0},
		'{'{CMD_STAT, 16'h0000, 16'h0000, STAT_SLEEPS}, 1'b0, '0},
		'{'{CMD_STAT, 16'h0000, 16'h0000, STAT_SENT}, 1'b0, '0},
		'{'{CMD_TICK, 16'hFFFF, 16'h0000, STAT_IDLE}, 1'b0, '0}
	};

	// Register settings per phase: byte time, ready wake, sleep wake, runway, queue limit
	phase_t phases [7] = '{
		'{'{16'd1, 16'd0, 16'd0, 32'd0, 7'd1}, 250, 30, 0, 1'b0},
		'{'{16'd0, 16'd5, 16'd9, 32'd3, 7'd0}, 250, 35, 0, 1'b0},
		'{'{16'd3, 16'd1, 16'd20, 32'd40, 7'd127}, 300, 60, 0, 1'b0},
		'{'{16'hFFFF, 16'd0, 16'd0, 32'd0, 7'd64}, 30, 40, 0, 1'b0},
		'{'{16'd2, 16'd0, 16'd7, 32'hFFFF_FFFF, 7'd64}, 350, 35, 0, 1'b1},
		'{'{16'd1, 16'd2, 16'd3, 32'd1, 7'd4}, 350, 45, 0, 1'b0},
		'{'{16'd4, 16'd0, 16'd12, 32'd25, 7'd8}, 400, 30, 0, 1'b0}
	};

	link_low_power_idle_tx_controller_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	function automatic logic [47:0] grow48(logic [47:0] acc, logic [47:0] step);
		logic [48:0] sum;
		sum = {1'b0, acc} + {1'b0, step};
		return sum[48] ? '1 : sum[47:0];
	endfunction

	function automatic longint frame_ticks(logic [15:0] bytes, logic [15:0] pen,
			logic [15:0] fab);
		return longint'(bytes) * longint'(cur_cfg.byte_time) + longint'(pen) + longint'(fab);
	endfunction

	function automatic int fifo_capacity();
		return (cur_cfg.queue_limit < QUEUE_DEPTH) ? int'(cur_cfg.queue_limit) : QUEUE_DEPTH;
	endfunction

	// Put the link in busy for a new frame and return its length
	function automatic logic [31:0] launch_frame(logic [15:0] bytes, logic [15:0] pen,
			logic [15:0] fab);
		longint len;
		len = frame_ticks(bytes, pen, fab);
		if (len > 64'hFFFF_FFFF)
			len = 64'hFFFF_FFFF;
		lk_mode = MODE_BUSY;
		lk_left = len[31:0];
		lk_idle_run = '0;
		if (n_sent != '1)
			n_sent++;
		return len[31:0];
	endfunction

	// Advance the link mirror by one request and return the result it must produce
	function automatic rsp_t predict_link(req_t r);
		rsp_t o;
		o = '0;
		case (r.cmd)
			CMD_TICK: begin
				fill_area = grow48(fill_area, 48'(fifo_fill));
				if (lk_mode == MODE_BUSY) begin
					tot_busy = grow48(tot_busy, 48'd1);
					if (lk_left != 0)
						lk_left--;
					if (lk_left == 0) begin
						o.tx_done = 1'b1;
						lk_mode = MODE_READY;
						lk_idle_run = '0;
						if (fifo_fill != 0) begin
							o.tx_started = 1'b1;
							o.tx_length = launch_frame(fifo_bytes[fifo_rd],
								cur_cfg.ready_wake_delay, 16'd0);
							fifo_rd++;
							fifo_fill--;
						end
					end
				end else if (lk_mode == MODE_SLEEP) begin
					tot_sleep = grow48(tot_sleep, 48'd1);
				end else begin
					tot_idle = grow48(tot_idle, 48'd1);
					if (lk_idle_run != '1)
						lk_idle_run++;
					if (lk_idle_run >= cur_cfg.idle_runway) begin
						lk_mode = MODE_SLEEP;
						lk_idle_run = '0;
						if (n_sleeps != '1)
							n_sleeps++;
						o.entered_sleep = 1'b1;
					end
				end
			end
			CMD_SEND: begin
				if (lk_mode == MODE_BUSY) begin
					if (int'(fifo_fill) < fifo_capacity()) begin
						fifo_bytes[fifo_wr] = r.frame_bytes;
						fifo_wr++;
						fifo_fill++;
						if (fifo_fill > peak_fill)
							peak_fill = fifo_fill;
					end else begin
						o.frame_dropped = 1'b1;
						if (n_dropped != '1)
							n_dropped++;
					end
				end else begin
					o.tx_started = 1'b1;
					o.tx_length = launch_frame(r.frame_bytes, (lk_mode == MODE_SLEEP) ?
						cur_cfg.sleep_wake_delay : cur_cfg.ready_wake_delay, r.fabric_delay);
				end
			end
			CMD_STAT: begin
				case (r.stat_select)
					STAT_IDLE: o.stat_value = tot_idle;
					STAT_SLEEP: o.stat_value = tot_sleep;
					STAT_BUSY: o.stat_value = tot_busy;
					STAT_SLEEPS: o.stat_value = 48'(n_sleeps);
					STAT_MAXQ: o.stat_value = 48'(peak_fill);
					STAT_INTEGRAL: o.stat_value = fill_area;
					STAT_SENT: o.stat_value = 48'(n_sent);
					STAT_DROPPED: o.stat_value = 48'(n_dropped);
				endcase
			end
			default: ;
		endcase
		o.link_state = lk_mode;
		o.queue_count = fifo_fill;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < 40)
			$display("mismatch in %s at result %0d: got %0h, want %0h", what, results_seen,
				got, want);
		mismatches++;
	endtask

	task automatic compare_result(input rsp_t got, input rsp_t want);
		if (got.link_state != want.link_state)
			report_mismatch("link_state", 64'(got.link_state), 64'(want.link_state));
		if (got.tx_started != want.tx_started)
			report_mismatch("tx_started", 64'(got.tx_started), 64'(want.tx_started));
		if (got.tx_length != want.tx_length)
			report_mismatch("tx_length", 64'(got.tx_length), 64'(want.tx_length));
		if (got.tx_done != want.tx_done)
			report_mismatch("tx_done", 64'(got.tx_done), 64'(want.tx_done));
		if (got.frame_dropped != want.frame_dropped)
			report_mismatch("frame_dropped", 64'(got.frame_dropped),
				64'(want.frame_dropped));
		if (got.entered_sleep != want.entered_sleep)
			report_mismatch("entered_sleep", 64'(got.entered_sleep),
				64'(want.entered_sleep));
		if (got.queue_count != want.queue_count)
			report_mismatch("queue_count", 64'(got.queue_count), 64'(want.queue_count));
		if (got.stat_value != want.stat_value)
			report_mismatch("stat_value", 64'(got.stat_value), 64'(want.stat_value));
	endtask

	// Offer one request with random gaps, then log its expected result once taken
	task automatic issue_request(input req_t r, input bit typed, input rsp_t golden);
		rsp_t want;
		@(negedge clk);
		while (!steady && $urandom_range(99) < 21) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		want = predict_link(r);
		expected_q.push_back(typed ? golden : want);
	endtask

	// Drop valid and wait for every outstanding result
	task automatic settle_link();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_BYTE_TIME: cur_cfg.byte_time = data[15:0];
			CFG_READY_WAKE: cur_cfg.ready_wake_delay = data[15:0];
			CFG_SLEEP_WAKE: cur_cfg.sleep_wake_delay = data[15:0];
			CFG_IDLE_RUNWAY: cur_cfg.idle_runway = data;
			CFG_QUEUE_LIMIT: cur_cfg.queue_limit = data[6:0];
			default: ;
		endcase
	endtask

	// Build a random request; keep frames short so the link keeps cycling through modes
	task automatic pick_request(input int send_pct, output req_t r, output bit counted);
		int roll;
		longint cost;
		logic [15:0] pen;
		r.frame_bytes = 16'($urandom);
		r.fabric_delay = 16'($urandom);
		r.stat_select = 3'($urandom);
		counted = 1'b1;
		roll = $urandom_range(99);
		if (roll < send_pct)
			r.cmd = CMD_SEND;
		else if (roll < send_pct + 12)
			r.cmd = CMD_STAT;
		else if (roll < send_pct + 15)
			r.cmd = CMD_NOP;
		else
			r.cmd = CMD_TICK;
		if (lk_mode == MODE_BUSY && lk_left > 48) begin
			// drain a long frame
			r.cmd = CMD_TICK;
			counted = 1'b0;
		end else if (r.cmd == CMD_SEND &&
				!(lk_mode == MODE_BUSY && int'(fifo_fill) >= fifo_capacity())) begin
			roll = $urandom_range(99);
			if (roll < 70)
				r.frame_bytes = 16'($urandom_range(7));
			else if (roll < 85)
				r.frame_bytes = 16'($urandom_range(255));
			if (lk_mode != MODE_BUSY && $urandom_range(99) < 85)
				r.fabric_delay = 16'($urandom_range(15));
			pen = (lk_mode == MODE_SLEEP) ? cur_cfg.sleep_wake_delay : cur_cfg.ready_wake_delay;
			cost = frame_ticks(r.frame_bytes, pen, (lk_mode == MODE_BUSY) ? 16'd0 : r.fabric_delay);
			if (cost > QUICK_FRAME_TICKS && !(long_left > 0 && cost <= SLOW_FRAME_TICKS)) begin
				r.frame_bytes = '0;
				r.fabric_delay = 16'($urandom_range(15));
				cost = frame_ticks('0, pen, (lk_mode == MODE_BUSY) ? 16'd0 : r.fabric_delay);
			end
			if (cost > QUICK_FRAME_TICKS) begin
				if (long_left > 0 && cost <= SLOW_FRAME_TICKS)
					long_left--;
				else
					r.cmd = CMD_TICK;
			end
		end
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Result side stalls
	always @(negedge clk) begin
		rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= 21);
	end

	// Check each taken result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_q.size() == 0)
				report_mismatch("unexpected result", 64'(rsp.stat_value), 64'd0);
			else
				compare_result(rsp, expected_q.pop_front());
			results_seen++;
		end
	end

	initial begin
		req_t r;
		bit counted;
		int done_items;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			issue_request(script[i].stim, script[i].typed, script[i].golden);

		foreach (phases[p]) begin
			// finish frames under the old settings; the first phase keeps its queue
			if (p != 0) begin
				while (lk_mode == MODE_BUSY) begin
					r = '{CMD_TICK, 16'($urandom), 16'($urandom), 3'($urandom)};
					issue_request(r, 1'b0, '0);
				end
			end
			settle_link();
			write_reg(CFG_BYTE_TIME, {16'($urandom), phases[p].regs.byte_time});
			write_reg(CFG_READY_WAKE, {16'($urandom), phases[p].regs.ready_wake_delay});
			write_reg(CFG_SLEEP_WAKE, {16'($urandom), phases[p].regs.sleep_wake_delay});
			write_reg(CFG_IDLE_RUNWAY, phases[p].regs.idle_runway);
			write_reg(CFG_QUEUE_LIMIT, {25'($urandom), phases[p].regs.queue_limit});
			write_reg(CFG_SPARE, $urandom);
			@(negedge clk);
			cfg_valid <= 1'b0;
			steady = phases[p].steady;
			long_left = phases[p].long_frames;
			done_items = 0;
			while (done_items < phases[p].items) begin
				pick_request(phases[p].send_pct, r, counted);
				issue_request(r, 1'b0, '0);
				if (counted) begin
					done_items++;
					// hold off once mid-phase until the link has answered everything
					if (done_items == phases[p].items / 2)
						settle_link();
				end
			end
			steady = 1'b0;
		end

		settle_link();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
